### rtl/xalu_pkg.sv
// ----------------------------------------------------------------------------
// xalu_pkg
// Shared opcodes, state codes, controller/datapath interface and size helpers.
// ----------------------------------------------------------------------------
package xalu_pkg;

	localparam logic [4:0] OP_ADD  = 5'd0;
	localparam logic [4:0] OP_ADC  = 5'd1;
	localparam logic [4:0] OP_SUB  = 5'd2;
	localparam logic [4:0] OP_SBB  = 5'd3;
	localparam logic [4:0] OP_AND  = 5'd4;
	localparam logic [4:0] OP_OR   = 5'd5;
	localparam logic [4:0] OP_XOR  = 5'd6;
	localparam logic [4:0] OP_SHL  = 5'd7;
	localparam logic [4:0] OP_SAL  = 5'd8;
	localparam logic [4:0] OP_SHR  = 5'd9;
	localparam logic [4:0] OP_SAR  = 5'd10;
	localparam logic [4:0] OP_MUL  = 5'd11;
	localparam logic [4:0] OP_IMUL = 5'd12;
	localparam logic [4:0] OP_DIV  = 5'd13;
	localparam logic [4:0] OP_IDIV = 5'd14;
	localparam logic [4:0] OP_MOD  = 5'd15;
	localparam logic [4:0] OP_IMOD = 5'd16;

	localparam logic [1:0] SZ_8  = 2'd0;
	localparam logic [1:0] SZ_16 = 2'd1;
	localparam logic [1:0] SZ_32 = 2'd2;

	// divider retires two quotient bits per step
	localparam logic [4:0] DIV_LAST_STEP = 5'd31;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_MUL,
		S_DIV,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {
		K_SIMPLE,
		K_MUL,
		K_DIV
	} kind_t;

	typedef struct packed {
		logic load;
		logic alu_go;
		logic mul_go;
		logic mul_fin;
		logic div_init;
		logic div_step;
		logic div_fin;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  div_last;
	} stat_t;

	function automatic logic [31:0] size_mask(input logic [1:0] sz);
		unique case (sz)
			SZ_8:    size_mask = 32'h0000_00FF;
			SZ_16:   size_mask = 32'h0000_FFFF;
			default: size_mask = 32'hFFFF_FFFF;
		endcase
	endfunction

	// bit n-1
	function automatic logic msb_of(input logic [32:0] v, input logic [1:0] sz);
		unique case (sz)
			SZ_8:    msb_of = v[7];
			SZ_16:   msb_of = v[15];
			default: msb_of = v[31];
		endcase
	endfunction

	// bit n
	function automatic logic carry_of(input logic [32:0] v, input logic [1:0] sz);
		unique case (sz)
			SZ_8:    carry_of = v[8];
			SZ_16:   carry_of = v[16];
			default: carry_of = v[32];
		endcase
	endfunction

	function automatic logic [31:0] sext32(input logic [31:0] x, input logic [1:0] sz);
		unique case (sz)
			SZ_8:    sext32 = {{24{x[7]}}, x[7:0]};
			SZ_16:   sext32 = {{16{x[15]}}, x[15:0]};
			default: sext32 = x;
		endcase
	endfunction

	function automatic logic [63:0] sext64(input logic [63:0] x, input logic [1:0] sz);
		unique case (sz)
			SZ_8:    sext64 = {{56{x[7]}}, x[7:0]};
			SZ_16:   sext64 = {{48{x[15]}}, x[15:0]};
			default: sext64 = {{32{x[31]}}, x[31:0]};
		endcase
	endfunction

endpackage

### rtl/xalu_ctrl.sv
// ----------------------------------------------------------------------------
// xalu_ctrl
// Sequencer: issues load, execute, multiply and divide commands.
// ----------------------------------------------------------------------------
module xalu_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  xalu_pkg::stat_t stat,
	output xalu_pkg::cmd_t  cmd,
	output logic            busy
);

	xalu_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xalu_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			xalu_pkg::S_IDLE: begin
				if (start) state_nx = xalu_pkg::S_EXEC;
			end
			xalu_pkg::S_EXEC: begin
				unique case (stat.kind)
					xalu_pkg::K_MUL: state_nx = xalu_pkg::S_MUL;
					xalu_pkg::K_DIV: state_nx = xalu_pkg::S_DIV;
					default:         state_nx = xalu_pkg::S_IDLE;
				endcase
			end
			xalu_pkg::S_MUL: state_nx = xalu_pkg::S_IDLE;
			xalu_pkg::S_DIV: begin
				if (stat.div_last) state_nx = xalu_pkg::S_FIN;
			end
			xalu_pkg::S_FIN: state_nx = xalu_pkg::S_IDLE;
			default:         state_nx = xalu_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		busy     = (state_q != xalu_pkg::S_IDLE);
		cmd.load = (state_q == xalu_pkg::S_IDLE) && start;
		unique case (state_q)
			xalu_pkg::S_EXEC: begin
				cmd.alu_go   = (stat.kind == xalu_pkg::K_SIMPLE);
				cmd.mul_go   = (stat.kind == xalu_pkg::K_MUL);
				cmd.div_init = (stat.kind == xalu_pkg::K_DIV);
			end
			xalu_pkg::S_MUL: cmd.mul_fin  = 1'b1;
			xalu_pkg::S_DIV: cmd.div_step = 1'b1;
			xalu_pkg::S_FIN: cmd.div_fin  = 1'b1;
			default: ;
		endcase
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == xalu_pkg::S_EXEC))
		else $error("accepted transfer did not enter execute");

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == xalu_pkg::S_DIV && stat.div_last) |=> (state_q == xalu_pkg::S_FIN))
		else $error("divider did not finish after last step");

	a_one_retire: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.alu_go, cmd.mul_fin, cmd.div_fin}) <= 1)
		else $error("more than one retire command");

endmodule

### rtl/xalu_dp.sv
// ----------------------------------------------------------------------------
// xalu_dp
// Operand latches, ALU/shifter, multiplier, 2-bit/step divider, flag state.
// ----------------------------------------------------------------------------
module xalu_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  xalu_pkg::cmd_t  cmd,
	output xalu_pkg::stat_t stat,
	input  logic [4:0]      mode,
	input  logic [63:0]     source_operand,
	input  logic [63:0]     dest_operand,
	input  logic [1:0]      size_code,
	output logic            done,
	output logic [63:0]     result,
	output logic            carry_out,
	output logic            parity_out,
	output logic            zero_out,
	output logic            sign_out,
	output logic            overflow_out,
	output logic            divide_error
);

	logic [4:0]  mode_q;
	logic [63:0] src_q, dst_q;
	logic [1:0]  size_q;

	logic        cf_q, pf_q, zf_q, sf_q, of_q;
	logic [63:0] res_q;
	logic        derr_q, done_q;

	logic [63:0] prod_q;
	logic [63:0] quo_q;
	logic [31:0] rem_q, dvs_q;
	logic        nd_q, nq_q, dz_q;
	logic [4:0]  cnt_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			src_q  <= source_operand;
			dst_q  <= dest_operand;
			size_q <= size_code;
		end
	end

	// --- operands at size ---
	logic [31:0] mask, a32, b32, a_sx, b_sx;
	logic [4:0]  k;
	assign mask = xalu_pkg::size_mask(size_q);
	assign a32  = dst_q[31:0] & mask;
	assign b32  = src_q[31:0] & mask;
	assign a_sx = xalu_pkg::sext32(a32, size_q);
	assign b_sx = xalu_pkg::sext32(b32, size_q);
	assign k    = src_q[4:0];

	always_comb begin
		stat.div_last = (cnt_q == xalu_pkg::DIV_LAST_STEP);
		unique case (mode_q)
			xalu_pkg::OP_MUL, xalu_pkg::OP_IMUL:  stat.kind = xalu_pkg::K_MUL;
			xalu_pkg::OP_DIV, xalu_pkg::OP_IDIV,
			xalu_pkg::OP_MOD, xalu_pkg::OP_IMOD:  stat.kind = xalu_pkg::K_DIV;
			default:                              stat.kind = xalu_pkg::K_SIMPLE;
		endcase
	end

	// --- combinational ALU and shifter ---
	logic               cin;
	logic [32:0]        sum33, diff33, bc33;
	logic [63:0]        shl_w;
	logic [32:0]        shr_w;
	logic signed [32:0] sar_in, sar_w;
	logic [31:0]        alu_res;
	logic               alu_cf, alu_of, alu_wr_co;

	assign cin    = ((mode_q == xalu_pkg::OP_ADC) || (mode_q == xalu_pkg::OP_SBB)) ? cf_q : 1'b0;
	assign sum33  = {1'b0, a32} + {1'b0, b32} + {32'b0, cin};
	assign diff33 = {1'b0, a32} - {1'b0, b32} - {32'b0, cin};
	assign bc33   = {1'b0, b32} + {32'b0, cin};
	assign shl_w  = {32'b0, a32} << k;
	assign shr_w  = {a32, 1'b0} >> k;
	assign sar_in = $signed({a_sx, 1'b0});
	assign sar_w  = sar_in >>> k;

	always_comb begin
		alu_res   = '0;
		alu_cf    = cf_q;
		alu_of    = of_q;
		alu_wr_co = 1'b1;
		unique case (mode_q)
			xalu_pkg::OP_ADD, xalu_pkg::OP_ADC: begin
				alu_res = sum33[31:0] & mask;
				alu_cf  = xalu_pkg::carry_of(sum33, size_q);
				alu_of  = xalu_pkg::msb_of({1'b0, (a32 ^ alu_res) & (b32 ^ alu_res)}, size_q);
			end
			xalu_pkg::OP_SUB, xalu_pkg::OP_SBB: begin
				alu_res = diff33[31:0] & mask;
				alu_cf  = {1'b0, a32} < bc33;
				alu_of  = xalu_pkg::msb_of({1'b0, (a32 ^ b32) & (a32 ^ alu_res)}, size_q);
			end
			xalu_pkg::OP_AND, xalu_pkg::OP_OR, xalu_pkg::OP_XOR: begin
				alu_res = (mode_q == xalu_pkg::OP_AND) ? (a32 & b32) :
				          (mode_q == xalu_pkg::OP_OR)  ? (a32 | b32) : (a32 ^ b32);
				alu_cf  = 1'b0;
				alu_of  = 1'b0;
			end
			xalu_pkg::OP_SHL, xalu_pkg::OP_SAL: begin
				alu_res = shl_w[31:0] & mask;
				if (k != 5'd0) begin
					alu_cf = xalu_pkg::carry_of(shl_w[32:0], size_q);
					if (k == 5'd1) alu_of = xalu_pkg::msb_of({1'b0, alu_res}, size_q) ^ alu_cf;
				end
			end
			xalu_pkg::OP_SHR: begin
				alu_res = shr_w[32:1];
				if (k != 5'd0) begin
					alu_cf = shr_w[0];
					if (k == 5'd1) alu_of = xalu_pkg::msb_of({1'b0, a32}, size_q);
				end
			end
			xalu_pkg::OP_SAR: begin
				alu_res = sar_w[32:1] & mask;
				if (k != 5'd0) begin
					alu_cf = sar_w[0];
					if (k == 5'd1) alu_of = 1'b0;
				end
			end
			default: alu_wr_co = 1'b0;  // undefined opcode: result zero, flags unchanged
		endcase
	end

	// --- multiplier: one 33x33 signed product, registered ---
	logic signed [32:0] ma, mb;
	logic signed [65:0] prod66;
	logic               is_imul, mul_ov;
	assign is_imul = (mode_q == xalu_pkg::OP_IMUL);
	assign ma      = is_imul ? $signed({a_sx[31], a_sx}) : $signed({1'b0, a32});
	assign mb      = is_imul ? $signed({b_sx[31], b_sx}) : $signed({1'b0, b32});
	assign prod66  = ma * mb;
	assign mul_ov  = is_imul ? (xalu_pkg::sext64(prod_q, size_q) != prod_q)
	                         : ((prod_q & ~{32'b0, mask}) != 64'd0);

	// --- divider: restoring, unsigned magnitudes ---
	logic        sgn_div, nd, ns;
	logic [63:0] dvs64, md, ms64;
	logic [32:0] r1, r2;
	logic [31:0] r1n, r2n;
	logic        q1, q2;
	logic [63:0] q_sg, r_sg, div_res;

	assign sgn_div = (mode_q == xalu_pkg::OP_IDIV) || (mode_q == xalu_pkg::OP_IMOD);
	assign dvs64   = sgn_div ? {{32{b_sx[31]}}, b_sx} : {32'b0, b32};
	assign nd      = sgn_div && dst_q[63];
	assign ns      = sgn_div && dvs64[63];
	assign md      = nd ? (64'd0 - dst_q) : dst_q;
	assign ms64    = ns ? (64'd0 - dvs64) : dvs64;

	assign r1  = {rem_q, quo_q[63]};
	assign q1  = (r1 >= {1'b0, dvs_q});
	assign r1n = q1 ? (r1[31:0] - dvs_q) : r1[31:0];
	assign r2  = {r1n, quo_q[62]};
	assign q2  = (r2 >= {1'b0, dvs_q});
	assign r2n = q2 ? (r2[31:0] - dvs_q) : r2[31:0];

	assign q_sg    = nq_q ? (64'd0 - quo_q) : quo_q;
	assign r_sg    = nd_q ? (64'd0 - {32'b0, rem_q}) : {32'b0, rem_q};
	assign div_res = ((mode_q == xalu_pkg::OP_DIV) || (mode_q == xalu_pkg::OP_IDIV))
	                 ? q_sg : r_sg;

	always_ff @(posedge clk) begin
		if (cmd.mul_go) prod_q <= prod66[63:0];
		if (cmd.div_init) begin
			quo_q <= md;
			rem_q <= '0;
			dvs_q <= ms64[31:0];
			nd_q  <= nd;
			nq_q  <= nd ^ ns;
			dz_q  <= (b32 == 32'd0);
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[61:0], q1, q2};
			rem_q <= r2n;
			cnt_q <= cnt_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.alu_go) res_q <= {32'b0, alu_res};
		else if (cmd.mul_fin) res_q <= prod_q;
		else if (cmd.div_fin) res_q <= dz_q ? 64'd0 : (div_res & {32'b0, mask});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cf_q   <= 1'b0;
			pf_q   <= 1'b0;
			zf_q   <= 1'b0;
			sf_q   <= 1'b0;
			of_q   <= 1'b0;
			derr_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.alu_go || cmd.mul_fin || cmd.div_fin;
			if (cmd.alu_go || cmd.mul_fin || cmd.div_fin) derr_q <= cmd.div_fin && dz_q;
			if (cmd.alu_go && alu_wr_co) begin
				cf_q <= alu_cf;
				of_q <= alu_of;
				pf_q <= ~^alu_res[7:0];
				zf_q <= (alu_res == 32'd0);
				sf_q <= xalu_pkg::msb_of({1'b0, alu_res}, size_q);
			end else if (cmd.mul_fin) begin
				cf_q <= mul_ov;
				of_q <= mul_ov;
			end
		end
	end

	assign done         = done_q;
	assign result       = res_q;
	assign carry_out    = cf_q;
	assign parity_out   = pf_q;
	assign zero_out     = zf_q;
	assign sign_out     = sf_q;
	assign overflow_out = of_q;
	assign divide_error = derr_q;

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cmd.alu_go || cmd.mul_fin || cmd.div_fin))
		else $error("result strobe without retire");

	a_derr_div: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && derr_q) |-> $past(cmd.div_fin))
		else $error("divide error outside division");

	a_div_flags: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_fin |=> (cf_q == $past(cf_q)) && (zf_q == $past(zf_q)))
		else $error("division changed flags");

endmodule

### rtl/x86_integer_alu_with_flags.sv
// ----------------------------------------------------------------------------
// x86_integer_alu_with_flags
// x86-style 8/16/32-bit integer ALU with CF/PF/ZF/SF/OF state.
// ----------------------------------------------------------------------------
//  channel  | handshake       | payload
//  ---------+-----------------+-------------------------------------------------
//  command  | start / busy    | mode, source_operand, dest_operand, size_code
//  result   | done (1 cycle)  | result, *_out flags, divide_error
//
//  A transfer is taken when start is high and busy is low; busy stays high
//  until the result strobe. add..sar retire from the execute state, mul/imul
//  from a multiply state (registered 33x33 multiplier), the divide group from
//  a finish state (restoring divider, 32 steps of two quotient bits each).
//  One item is in flight at a time; the next may be issued in the done cycle.
//  done is a single-cycle strobe; the receiver cannot stall it.
//  arst_n clears the flags and the sequencer.
// ----------------------------------------------------------------------------
module x86_integer_alu_with_flags (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [4:0]  mode,
	input  logic [63:0] source_operand,
	input  logic [63:0] dest_operand,
	input  logic [1:0]  size_code,
	output logic        done,
	output logic [63:0] result,
	output logic        carry_out,
	output logic        parity_out,
	output logic        zero_out,
	output logic        sign_out,
	output logic        overflow_out,
	output logic        divide_error
);

	xalu_pkg::cmd_t  cmd;
	xalu_pkg::stat_t stat;

	// sequencer
	xalu_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	// operand latches, execution units, flag registers
	xalu_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.mode          (mode),
		.source_operand(source_operand),
		.dest_operand  (dest_operand),
		.size_code     (size_code),
		.done          (done),
		.result        (result),
		.carry_out     (carry_out),
		.parity_out    (parity_out),
		.zero_out      (zero_out),
		.sign_out      (sign_out),
		.overflow_out  (overflow_out),
		.divide_error  (divide_error)
	);

endmodule

### tb/x86_integer_alu_with_flags_tb.sv
// ----------------------------------------------------------------------------
// x86_integer_alu_with_flags_tb
// Self-checking bench: directed corner items per operation, then random items
// with random issue gaps; each result strobe is checked against a flag-tracking
// predictor, field by field, in order.
// ----------------------------------------------------------------------------
module x86_integer_alu_with_flags_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 680;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [4:0]  mode;
	logic [63:0] source_operand;
	logic [63:0] dest_operand;
	logic [1:0]  size_code;
	logic        done;
	logic [63:0] result;
	logic        carry_out;
	logic        parity_out;
	logic        zero_out;
	logic        sign_out;
	logic        overflow_out;
	logic        divide_error;

	typedef struct {
		logic [63:0] res;
		logic        cf, pf, zf, sf, of, derr;
	} alu_out_t;

	// predictor flag state
	logic     p_cf, p_pf, p_zf, p_sf, p_of;
	alu_out_t expected_q[$];
	int       errors;
	int       cycles;

	x86_integer_alu_with_flags u_dut (.*);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [63:0] sx(logic [63:0] x, int unsigned n);
		logic [63:0] sb;
		logic [63:0] msk;
		sb  = 64'd1 << (n - 1);
		msk = (64'd1 << n) - 1;
		return ((x & msk) ^ sb) - sb;
	endfunction

	task automatic update_pzs(logic [63:0] r, int unsigned n);
		logic [63:0] msk;
		msk = (64'd1 << n) - 1;
		p_pf = ~^r[7:0];
		p_zf = (r & msk) == 0;
		p_sf = r[n-1];
	endtask

	// Compute one ALU result and advance the predictor flags.
	task automatic predict_alu(logic [4:0] op, logic [63:0] s, logic [63:0] d,
			logic [1:0] sz);
		int unsigned n;
		int unsigned k;
		logic [63:0] msk, a, b, r, c, sum, sa, dv, md, ms, q, ov;
		logic        derr, nd, ns;
		alu_out_t    o;
		n    = (sz == xalu_pkg::SZ_8) ? 8 : ((sz == xalu_pkg::SZ_16) ? 16 : 32);
		msk  = (64'd1 << n) - 1;
		a    = d & msk;
		b    = s & msk;
		k    = {27'd0, s[4:0]};
		r    = '0;
		derr = 1'b0;
		case (op)
			xalu_pkg::OP_ADD, xalu_pkg::OP_ADC: begin
				c = (op == xalu_pkg::OP_ADC) ? 64'(p_cf) : 64'd0;
				sum = a + b + c;
				r = sum & msk;
				p_cf = sum[n];
				ov = (a ^ r) & (b ^ r);
				p_of = ov[n-1];
				update_pzs(r, n);
			end
			xalu_pkg::OP_SUB, xalu_pkg::OP_SBB: begin
				c = (op == xalu_pkg::OP_SBB) ? 64'(p_cf) : 64'd0;
				r = (a - b - c) & msk;
				p_cf = a < b + c;
				ov = (a ^ b) & (a ^ r);
				p_of = ov[n-1];
				update_pzs(r, n);
			end
			xalu_pkg::OP_AND, xalu_pkg::OP_OR, xalu_pkg::OP_XOR: begin
				r = (op == xalu_pkg::OP_AND) ? (a & b)
					: ((op == xalu_pkg::OP_OR) ? (a | b) : (a ^ b));
				p_cf = 1'b0;
				p_of = 1'b0;
				update_pzs(r, n);
			end
			xalu_pkg::OP_SHL, xalu_pkg::OP_SAL: begin
				r = (a << k) & msk;
				if (k != 0) begin
					p_cf = (k <= n) ? a[n-k] : 1'b0;
					if (k == 1) p_of = r[n-1] ^ p_cf;
				end
				update_pzs(r, n);
			end
			xalu_pkg::OP_SHR: begin
				r = a >> k;
				if (k != 0) begin
					p_cf = (k <= n) ? a[k-1] : 1'b0;
					if (k == 1) p_of = a[n-1];
				end
				update_pzs(r, n);
			end
			xalu_pkg::OP_SAR: begin
				sa = sx(a, n);
				r = 64'($signed(sa) >>> k) & msk;
				if (k != 0) begin
					p_cf = sa[k-1];
					if (k == 1) p_of = 1'b0;
				end
				update_pzs(r, n);
			end
			xalu_pkg::OP_MUL: begin
				r = a * b;
				p_cf = (r >> n) != 0;
				p_of = p_cf;
			end
			xalu_pkg::OP_IMUL: begin
				r = sx(a, n) * sx(b, n);
				p_cf = sx(r, n) != r;
				p_of = p_cf;
			end
			xalu_pkg::OP_DIV, xalu_pkg::OP_MOD: begin
				if (b == 0) derr = 1'b1;
				else r = ((op == xalu_pkg::OP_DIV) ? d / b : d % b) & msk;
			end
			xalu_pkg::OP_IDIV, xalu_pkg::OP_IMOD: begin
				dv = sx(b, n);
				if (dv == 0) derr = 1'b1;
				else begin
					nd = d[63];
					ns = dv[63];
					md = nd ? -d : d;
					ms = ns ? -dv : dv;
					if (op == xalu_pkg::OP_IDIV) begin
						q = md / ms;
						r = ((nd != ns) ? -q : q) & msk;
					end else begin
						q = md % ms;
						r = (nd ? -q : q) & msk;
					end
				end
			end
			default: r = '0;
		endcase
		o.res = r; o.cf = p_cf; o.pf = p_pf; o.zf = p_zf;
		o.sf = p_sf; o.of = p_of; o.derr = derr;
		expected_q.push_back(o);
	endtask

	// Idle cycles between commands: mostly none or short, sometimes long.
	task automatic idle_gap();
		int unsigned g;
		g = $urandom_range(0, 99);
		if (g < 50) g = 0;
		else if (g < 92) g = $urandom_range(1, 3);
		else g = $urandom_range(10, 45);
		if (g != 0) start <= 1'b0;
		repeat (g) @(posedge clk);
	endtask

	// One command transfer; predicts at acceptance. start stays high so a
	// following command can go out back to back.
	task automatic issue_op(logic [4:0] op, logic [63:0] s, logic [63:0] d,
			logic [1:0] sz);
		start          <= 1'b1;
		mode           <= op;
		source_operand <= s;
		dest_operand   <= d;
		size_code      <= sz;
		do @(posedge clk); while (busy);
		predict_alu(op, s, d, sz);
	endtask

	// Result checker: every strobe pops the oldest expectation.
	always @(posedge clk) begin
		alu_out_t e;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				$error("result with nothing expected: %h", result);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (result !== e.res) begin
					$error("result exp %h got %h", e.res, result); errors++;
				end
				if (carry_out !== e.cf) begin
					$error("carry_out exp %b got %b", e.cf, carry_out); errors++;
				end
				if (parity_out !== e.pf) begin
					$error("parity_out exp %b got %b", e.pf, parity_out); errors++;
				end
				if (zero_out !== e.zf) begin
					$error("zero_out exp %b got %b", e.zf, zero_out); errors++;
				end
				if (sign_out !== e.sf) begin
					$error("sign_out exp %b got %b", e.sf, sign_out); errors++;
				end
				if (overflow_out !== e.of) begin
					$error("overflow_out exp %b got %b", e.of, overflow_out); errors++;
				end
				if (divide_error !== e.derr) begin
					$error("divide_error exp %b got %b", e.derr, divide_error); errors++;
				end
			end
		end
	end

	function automatic logic [63:0] rnd64();
		return {$urandom(), $urandom()};
	endfunction

	// Operand biased toward size edges: zero, one, all ones, sign bit, largest positive, random.
	function automatic logic [63:0] edgy(logic [1:0] sz);
		int unsigned n;
		logic [63:0] msk;
		n   = (sz == xalu_pkg::SZ_8) ? 8 : ((sz == xalu_pkg::SZ_16) ? 16 : 32);
		msk = (64'd1 << n) - 1;
		case ($urandom_range(0, 7))
			0: return 64'd0;
			1: return msk;
			2: return 64'd1 << (n - 1);
			3: return (64'd1 << (n - 1)) - 1;
			4: return 64'd1;
			default: return rnd64();
		endcase
	endfunction

	task automatic test_directed();
		// arithmetic extremes; carry chain into adc/sbb
		issue_op(xalu_pkg::OP_ADD, 64'hFF, 64'h01, xalu_pkg::SZ_8);
		issue_op(xalu_pkg::OP_ADC, 64'h00, 64'hFF, xalu_pkg::SZ_8);
		issue_op(xalu_pkg::OP_ADD, 64'h7FFF_FFFF, 64'h1, xalu_pkg::SZ_32);
		issue_op(xalu_pkg::OP_SUB, 64'h1, 64'h0, xalu_pkg::SZ_16);
		issue_op(xalu_pkg::OP_SBB, 64'hFFFF, 64'hFFFF, xalu_pkg::SZ_16);
		issue_op(xalu_pkg::OP_SBB, 64'h0, 64'h8000, xalu_pkg::SZ_16);
		issue_op(xalu_pkg::OP_AND, '1, '1, xalu_pkg::SZ_32);
		issue_op(xalu_pkg::OP_OR, 64'h0, 64'h0, xalu_pkg::SZ_8);
		issue_op(xalu_pkg::OP_XOR, 64'h5A, 64'hA5, xalu_pkg::SZ_8);
		// shifts: count 1, zero count, maximum count
		issue_op(xalu_pkg::OP_SHL, 64'h1, 64'hC0, xalu_pkg::SZ_8);
		issue_op(xalu_pkg::OP_SAL, 64'h20, 64'hFFFF_FFFF, xalu_pkg::SZ_16);
		issue_op(xalu_pkg::OP_SHR, 64'h1, 64'h81, xalu_pkg::SZ_8);
		issue_op(xalu_pkg::OP_SHR, 64'h0, 64'h0, xalu_pkg::SZ_8);
		issue_op(xalu_pkg::OP_SAR, 64'h1F, 64'h8000_0000, xalu_pkg::SZ_32);
		issue_op(xalu_pkg::OP_SAR, 64'h1, 64'h8001, xalu_pkg::SZ_16);
		issue_op(xalu_pkg::OP_MUL, 64'hFFFF_FFFF, 64'hFFFF_FFFF, xalu_pkg::SZ_32);
		issue_op(xalu_pkg::OP_IMUL, 64'h80, 64'h80, xalu_pkg::SZ_8);
		issue_op(xalu_pkg::OP_IMUL, 64'hFFFF, 64'h2, xalu_pkg::SZ_16);
		// division: zero divisor, overflowing quotient, negative dividend
		issue_op(xalu_pkg::OP_DIV, 64'h0, '1, xalu_pkg::SZ_32);
		issue_op(xalu_pkg::OP_DIV, 64'h1, '1, xalu_pkg::SZ_8);
		issue_op(xalu_pkg::OP_IDIV, 64'hFF, 64'h8000_0000_0000_0000, xalu_pkg::SZ_8);
		issue_op(xalu_pkg::OP_MOD, 64'hFFFF_FFFF, '1, xalu_pkg::SZ_32);
		issue_op(xalu_pkg::OP_IMOD, 64'hFD, -64'sd7, xalu_pkg::SZ_8);
		issue_op(xalu_pkg::OP_IMOD, 64'h0, 64'h5, xalu_pkg::SZ_16);
		// size code 3, undefined mode
		issue_op(xalu_pkg::OP_ADD, 64'hFFFF_FFFF, 64'h1, 2'd3);
		issue_op(5'd31, rnd64(), rnd64(), xalu_pkg::SZ_8);
	endtask

	task automatic test_random();
		logic [4:0] op;
		logic [1:0] sz;
		logic [63:0] s;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(17, 31))
				: 5'($urandom_range(0, 16));
			sz = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
			s  = edgy(sz);
			// small shift counts are the interesting ones
			if (op >= xalu_pkg::OP_SHL && op <= xalu_pkg::OP_SAR && $urandom_range(0, 1))
				s[4:0] = 5'($urandom_range(0, 2));
			issue_op(op, s, ($urandom_range(0, 3) == 0) ? rnd64() : edgy(sz), sz);
			idle_gap();
		end
	endtask

	initial begin
		errors         = 0;
		cycles         = 0;
		arst_n         = 1'b0;
		start          = 1'b0;
		mode           = xalu_pkg::OP_ADD;
		source_operand = '0;
		dest_operand   = '0;
		size_code      = xalu_pkg::SZ_8;
		p_cf = 0; p_pf = 0; p_zf = 0; p_sf = 0; p_of = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		start <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### x86_integer_alu_with_flags.f
rtl/xalu_pkg.sv
rtl/xalu_ctrl.sv
rtl/xalu_dp.sv
rtl/x86_integer_alu_with_flags.sv
tb/x86_integer_alu_with_flags_tb.sv
